// ----- hdl/hsirgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsirgb_pkg;

    // Field widths of the stream payloads.
    localparam int HUE_W       = 9;
    localparam int PCT_W       = 7;
    localparam int CH_W        = 8;
    localparam int OFS_W       = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam int HUE_FULL    = 360;
    localparam int SECTOR_SPAN = 120;
    localparam int HALF_SPAN   = SECTOR_SPAN / 2;
    localparam int PCT_MAX     = 100;

    // Fraction bits of the hue ratio table.
    localparam int RATIO_FRAC_BITS = 14;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 3;
    localparam int SR_W            = RATIO_FRAC_BITS + 9;
    localparam int XC_W            = RATIO_FRAC_BITS + 11;
    localparam int X_W             = RATIO_FRAC_BITS + 9;

    // 255 * intensity, channel numerators after the fraction shift, and 255 * (100 - s) * i.
    localparam int I255_W      = 15;
    localparam int LEVEL_SHIFT = CH_W;
    localparam int M_W         = 23;
    localparam int P_W         = 22;

    // Constant division by reciprocal multiply with a single correction step.
    localparam int DIV_SHIFT = 32;
    localparam int DIV_W     = 15;
    localparam int RECIP_W   = 19;
    localparam int PROD_W    = M_W + RECIP_W;
    localparam int Q_W       = CH_W + 1;
    localparam logic [DIV_W-1:0]   DIV_RGB     = 15'd30000;
    localparam logic [DIV_W-1:0]   DIV_WHITE   = 15'd10000;
    localparam logic [RECIP_W-1:0] RECIP_RGB   =
        RECIP_W'((64'd1 << DIV_SHIFT) / 64'(DIV_RGB));
    localparam logic [RECIP_W-1:0] RECIP_WHITE =
        RECIP_W'((64'd1 << DIV_SHIFT) / 64'(DIV_WHITE));
    localparam logic [CH_W-1:0]    CH_MAX      = '1;

    // Queue between the front decoder and the arithmetic pipe.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_WHITE_MODE = '0;

    // Which channel takes the leading term.
    typedef enum logic [1:0] {
        SEC_R,
        SEC_G,
        SEC_B
    } t_sector;

    typedef struct packed {
        t_sector            sector;
        logic [OFS_W-1:0]   offset;
        logic [PCT_W-1:0]   sat;
        logic [PCT_W-1:0]   inten;
    } t_item;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    // Table build, evaluated at elaboration only.
    localparam longint Q28_ONE = longint'(1) << 28;
    localparam longint PI_Q28  = 843314857;

    // The Taylor terms are divided by (2k - 1) * 2k for k = 1 to 12.
    function automatic longint cos_q28(input int deg);
        longint x;
        longint x2;
        longint term;
        longint sum;
        int     mag;
        mag  = (deg < 0) ? -deg : deg;
        x    = longint'(mag) * PI_Q28 / 180;
        x2   = x * x / Q28_ONE;
        term = Q28_ONE;
        sum  = Q28_ONE;
        term = -(term * x2 / Q28_ONE) / 2;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 12;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 30;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 56;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 90;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 132;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 182;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 240;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 306;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 380;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 462;
        sum  = sum + term;
        term = -(term * x2 / Q28_ONE) / 552;
        sum  = sum + term;
        return sum;
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_entry(input int ofs);
        longint num;
        longint den;
        longint p;
        longint mag;
        longint rem;
        longint q;
        num = cos_q28(ofs);
        den = cos_q28(HALF_SPAN - ofs);
        p   = num * (longint'(1) << RATIO_FRAC_BITS);
        mag = (p < 0) ? -p : p;
        if (den <= 0) begin
            den = 1;
        end
        // Round half up on the magnitude, then a restoring long division.
        rem = mag + (den >>> 1);
        q   = 0;
        for (int b = RATIO_W; b >= 0; b--) begin
            if (rem >= (den <<< b)) begin
                rem = rem - (den <<< b);
                q   = q + (longint'(1) << b);
            end
        end
        return RATIO_W'((p < 0) ? -q : q);
    endfunction

    typedef logic [SECTOR_SPAN-1:0][RATIO_W-1:0] t_ratio_rom;

    function automatic t_ratio_rom build_ratio_rom();
        t_ratio_rom rom;
        for (int o = 0; o < SECTOR_SPAN; o++) begin
            rom[o] = ratio_entry(o);
        end
        return rom;
    endfunction

    // cos(o) / cos(60 - o) in signed fixed point, one entry per degree of offset.
    localparam t_ratio_rom RATIO_ROM = build_ratio_rom();

endpackage

`default_nettype wire

// ----- hdl/hsirgb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsirgb_front import hsirgb_pkg::*; (
    input  logic                  i_valid,
    // hue_degrees [8:0], saturation_percent [15:9], intensity_percent [22:16]
    input  logic [IN_TDATA_W-1:0] i_tdata,
    output logic                  o_ready,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam logic [HUE_W-1:0] HUE_WRAP  = HUE_W'(HUE_FULL);
    localparam logic [HUE_W-1:0] HUE_SEC_G = HUE_W'(SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_SEC_B = HUE_W'(2 * SECTOR_SPAN);
    localparam logic [PCT_W-1:0] PCT_TOP   = PCT_W'(PCT_MAX);

    logic [HUE_W-1:0] hue_raw;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat_raw;
    logic [PCT_W-1:0] int_raw;

    always_comb begin
        hue_raw = i_tdata[HUE_W-1:0];
        sat_raw = i_tdata[HUE_W +: PCT_W];
        int_raw = i_tdata[HUE_W + PCT_W +: PCT_W];

        // Out-of-range hue wraps once; saturation and intensity clip at full scale.
        hue = (hue_raw >= HUE_WRAP) ? hue_raw - HUE_WRAP : hue_raw;

        o_item.sat   = (sat_raw > PCT_TOP) ? PCT_TOP : sat_raw;
        o_item.inten = (int_raw > PCT_TOP) ? PCT_TOP : int_raw;

        priority if (hue < HUE_SEC_G) begin
            o_item.sector = SEC_R;
            o_item.offset = hue[OFS_W-1:0];
        end else if (hue < HUE_SEC_B) begin
            o_item.sector = SEC_G;
            o_item.offset = OFS_W'(hue - HUE_SEC_G);
        end else begin
            o_item.sector = SEC_B;
            o_item.offset = OFS_W'(hue - HUE_SEC_B);
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

`default_nettype wire

// ----- hdl/hsirgb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsirgb_queue import hsirgb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

// ----- hdl/hsirgb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsirgb_back import hsirgb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_white_mode,
    input  logic                   i_item_valid,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_tvalid,
    // red [7:0], green [15:8], blue [23:16], white [31:24]
    output logic [OUT_TDATA_W-1:0] o_tdata,
    input  logic                   i_tready
);

    localparam logic signed [XC_W-1:0] PCT_ONE = XC_W'(PCT_MAX) << RATIO_FRAC_BITS;
    localparam logic [PCT_W-1:0]       PCT_TOP = PCT_W'(PCT_MAX);

    // Quotient by a constant: the reciprocal estimate is never high and at most one low.
    function automatic logic [CH_W-1:0] fix_quot(
        input logic [M_W-1:0]   m,
        input logic [Q_W-1:0]   q0,
        input logic [DIV_W-1:0] d
    );
        logic [M_W:0] base;
        logic [M_W:0] rem;
        logic [Q_W:0] q;
        base = (M_W + 1)'(q0) * (M_W + 1)'(d);
        rem  = (M_W + 1)'(m) - base;
        q    = (Q_W + 1)'(q0) + (Q_W + 1)'(rem >= (M_W + 1)'(d));
        return (q > (Q_W + 1)'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
    endfunction

    // Stage handshake: a stage moves on when it is empty or the one after it moves.
    logic adv1, adv2, adv3, adv4, adv5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign adv5  = !r_v5 || i_tready;
    assign adv4  = !r_v4 || adv5;
    assign adv3  = !r_v3 || adv4;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_item_valid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_item_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
            if (adv5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 1: table lookup and the small scalings.
    logic [RATIO_W-1:0] ratio_rd;
    logic [I255_W-1:0]  i255;
    logic [PCT_W-1:0]   sat_comp;

    logic signed [RATIO_W-1:0] r1_ratio;
    logic [PCT_W-1:0]          r1_sat;
    logic [PCT_W-1:0]          r1_sc;
    logic [I255_W-1:0]         r1_i255;
    t_sector                   r1_sector;

    assign ratio_rd = RATIO_ROM[i_item.offset];
    assign i255     = (I255_W'(i_item.inten) << LEVEL_SHIFT) - I255_W'(i_item.inten);
    assign sat_comp = PCT_TOP - i_item.sat;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_ratio  <= $signed(ratio_rd);
            r1_sat    <= i_item.sat;
            r1_sc     <= sat_comp;
            r1_i255   <= i255;
            r1_sector <= i_item.sector;
        end
    end

    // Stage 2: s * ratio and the unsaturated product 255 * i * (100 - s).
    logic signed [RATIO_W+PCT_W:0] sr_full;
    logic [P_W-1:0]                p_full;

    logic signed [SR_W-1:0] r2_sr;
    logic [PCT_W-1:0]       r2_sat;
    logic [I255_W-1:0]      r2_i255;
    logic [P_W-1:0]         r2_p;
    t_sector                r2_sector;

    assign sr_full = $signed({1'b0, r1_sat}) * r1_ratio;
    assign p_full  = P_W'(r1_i255) * P_W'(r1_sc);

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_sr     <= $signed(sr_full[SR_W-1:0]);
            r2_sat    <= r1_sat;
            r2_i255   <= r1_i255;
            r2_p      <= p_full;
            r2_sector <= r1_sector;
        end
    end

    // Stage 3: channel weights, then scale by 255 * i and drop the fraction.
    logic signed [XC_W-1:0]    sr_x;
    logic signed [XC_W-1:0]    sat_one;
    logic signed [XC_W-1:0]    x1;
    logic signed [XC_W-1:0]    x2;
    logic [I255_W+X_W-1:0]     n1;
    logic [I255_W+X_W-1:0]     n2;

    logic [M_W-1:0] r3_m1;
    logic [M_W-1:0] r3_m2;
    logic [P_W-1:0] r3_p;
    t_sector        r3_sector;

    always_comb begin
        sr_x    = XC_W'(r2_sr);
        sat_one = XC_W'(r2_sat) << RATIO_FRAC_BITS;
        if (i_white_mode) begin
            x1 = sat_one + sr_x;
            x2 = (sat_one <<< 1) - sr_x;
        end else begin
            x1 = PCT_ONE + sr_x;
            x2 = PCT_ONE + sat_one - sr_x;
        end
        n1 = (I255_W + X_W)'(r2_i255) * (I255_W + X_W)'(x1[X_W-1:0]);
        n2 = (I255_W + X_W)'(r2_i255) * (I255_W + X_W)'(x2[X_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_m1     <= n1[RATIO_FRAC_BITS +: M_W];
            r3_m2     <= n2[RATIO_FRAC_BITS +: M_W];
            r3_p      <= r2_p;
            r3_sector <= r2_sector;
        end
    end

    // Stage 4: reciprocal estimates of the four quotients.
    logic [PROD_W-1:0] pr1;
    logic [PROD_W-1:0] pr2;
    logic [PROD_W-1:0] pr3;
    logic [PROD_W-1:0] prw;

    logic [Q_W-1:0] r4_q1;
    logic [Q_W-1:0] r4_q2;
    logic [Q_W-1:0] r4_q3;
    logic [Q_W-1:0] r4_qw;
    logic [M_W-1:0] r4_m1;
    logic [M_W-1:0] r4_m2;
    logic [P_W-1:0] r4_p;
    t_sector        r4_sector;

    assign pr1 = PROD_W'(r3_m1) * PROD_W'(RECIP_RGB);
    assign pr2 = PROD_W'(r3_m2) * PROD_W'(RECIP_RGB);
    assign pr3 = PROD_W'(r3_p) * PROD_W'(RECIP_RGB);
    assign prw = PROD_W'(r3_p) * PROD_W'(RECIP_WHITE);

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_q1     <= pr1[DIV_SHIFT +: Q_W];
            r4_q2     <= pr2[DIV_SHIFT +: Q_W];
            r4_q3     <= pr3[DIV_SHIFT +: Q_W];
            r4_qw     <= prw[DIV_SHIFT +: Q_W];
            r4_m1     <= r3_m1;
            r4_m2     <= r3_m2;
            r4_p      <= r3_p;
            r4_sector <= r3_sector;
        end
    end

    // Stage 5: correct the quotients, pick the mode and rotate by sector.
    logic [CH_W-1:0] c1, c2, c3, cw;
    logic [CH_W-1:0] red, green, blue, white;
    logic [OUT_TDATA_W-1:0] r_tdata;

    always_comb begin
        c1    = fix_quot(r4_m1, r4_q1, DIV_RGB);
        c2    = fix_quot(r4_m2, r4_q2, DIV_RGB);
        c3    = i_white_mode ? '0 : fix_quot(M_W'(r4_p), r4_q3, DIV_RGB);
        cw    = fix_quot(M_W'(r4_p), r4_qw, DIV_WHITE);
        white = i_white_mode ? cw : '0;
        unique case (r4_sector)
            SEC_G: begin
                green = c1;
                blue  = c2;
                red   = c3;
            end
            SEC_B: begin
                blue  = c1;
                red   = c2;
                green = c3;
            end
            default: begin
                red   = c1;
                green = c2;
                blue  = c3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_tdata <= {white, blue, green, red};
        end
    end

    assign o_tvalid = r_v5;
    assign o_tdata  = r_tdata;

endmodule

`default_nettype wire

// ----- hdl/hsi_to_rgb_rgbw_convert.sv -----
// Path: an accepted input beat is written to the queue, then passes the five pipe stages.
// Throughput: one colour per clock while the master side does not stall, set by the
// five-stage multiply pipe taking one beat a cycle; a four-entry queue lets the input side
// keep accepting while the output side stalls.
// Reset: synchronous, active low; empties the queue and the pipe and sets white_mode to RGB.
`timescale 1ns / 1ps
`default_nettype none

module hsi_to_rgb_rgbw_convert import hsirgb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // hue_degrees [8:0], saturation_percent [15:9], intensity_percent [22:16], zero [23]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], white [31:24]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic    r_white_mode;
    logic    w_push;
    logic    w_pop;
    t_item   w_item_in;
    t_item   w_item_head;
    t_q_stat w_q_stat;
    logic    w_reg_hit;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_WHITE_MODE);
    assign prdata    = w_reg_hit ? CFG_DATA_W'(r_white_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_white_mode <= pwdata[0];
        end
    end

    hsirgb_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_item   (w_item_in)
    );

    hsirgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item_in),
        .i_pop   (w_pop),
        .o_item  (w_item_head),
        .o_stat  (w_q_stat)
    );

    hsirgb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_white_mode (r_white_mode),
        .i_item_valid (!w_q_stat.empty),
        .i_item       (w_item_head),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .o_tdata      (m_axis_tdata),
        .i_tready     (m_axis_tready)
    );

`ifndef SYNTH
    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid straight after reset");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("queue read while empty");

    a_count_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_q_stat.count == $past(w_q_stat.count) + 1'b1))
        else $error("queue fill count did not follow a write");

    a_count_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (w_q_stat.count == $past(w_q_stat.count) - 1'b1))
        else $error("queue fill count did not follow a read");
`endif

endmodule

`default_nettype wire
